[rtl/epe_pkg.sv]
// ----------------------------------------------------------------------------
// epe_pkg: shared types and constants of the erasure parity encoder
// Holds the item structs, register indexes, command codes and a field
// multiply function; the datapath itself uses epe_gf_mul.
// ----------------------------------------------------------------------------
package epe_pkg;

	localparam int SYM_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int RESULT_LIMIT = 16;

	// Command codes of an input item.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_FIELD_MODE   = 3'd0;
	localparam logic [2:0] REG_DATA_COUNT   = 3'd1;
	localparam logic [2:0] REG_PARITY_COUNT = 3'd2;
	localparam logic [2:0] REG_SHARD_LEN    = 3'd3;
	localparam logic [2:0] REG_POLY_BYTE    = 3'd4;
	localparam logic [2:0] REG_POLY_WORD    = 3'd5;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  parity_row;
		logic [4:0]  shard_index;
		logic [15:0] symbol_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] parity_value;
		logic [3:0]  parity_index;
		logic        column_last;
		logic        block_last;
	} out_item_t;

	// Shift-and-add multiply in GF(2^8) or GF(2^16); operands are pre-masked.
	function automatic logic [15:0] gf_mul(input logic [15:0] a_in, input logic [15:0] b,
			input logic word_mode, input logic [15:0] poly_low);
		logic [15:0] a;
		logic [15:0] acc;
		logic        top;
		a   = a_in;
		acc = '0;
		for (int i = 0; i < SYM_W; i++) begin
			if (b[i]) begin
				acc = acc ^ a;
			end
			top = word_mode ? a[15] : a[7];
			a   = {a[14:0], 1'b0};
			if (!word_mode) begin
				a[15:8] = '0;
			end
			if (top) begin
				a = a ^ poly_low;
			end
		end
		return acc;
	endfunction

endpackage

[rtl/epe_gf_mul.sv]
// ----------------------------------------------------------------------------
// epe_gf_mul: registered two-stage field multiplier
// Splits the 16-bit carry-less product into two 8-step halves, one per stage.
// ----------------------------------------------------------------------------
module epe_gf_mul (
	input  logic        clk,
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic        word_mode,
	input  logic [15:0] poly_low,
	output logic [15:0] prod
);
	import epe_pkg::*;

	logic [15:0] acc_s1;
	logic [15:0] a_s1;
	logic [7:0]  b_hi_s1;
	logic        mode_s1;
	logic [15:0] poly_s1;
	logic [15:0] acc_c;
	logic [15:0] a_c;
	logic [15:0] acc2_c;
	logic [15:0] a2_c;
	logic        top_c;
	logic        top2_c;

	// First eight multiplier bits.
	always_comb begin
		acc_c = '0;
		a_c   = a;
		top_c = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc_c = acc_c ^ a_c;
			end
			top_c = word_mode ? a_c[15] : a_c[7];
			a_c   = {a_c[14:0], 1'b0};
			if (!word_mode) begin
				a_c[15:8] = '0;
			end
			if (top_c) begin
				a_c = a_c ^ poly_low;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_s1  <= acc_c;
		a_s1    <= a_c;
		b_hi_s1 <= word_mode ? b[15:8] : 8'h00;
		mode_s1 <= word_mode;
		poly_s1 <= poly_low;
	end

	// Upper eight multiplier bits.
	always_comb begin
		acc2_c = acc_s1;
		a2_c   = a_s1;
		top2_c = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (b_hi_s1[i]) begin
				acc2_c = acc2_c ^ a2_c;
			end
			top2_c = mode_s1 ? a2_c[15] : a2_c[7];
			a2_c   = {a2_c[14:0], 1'b0};
			if (!mode_s1) begin
				a2_c[15:8] = '0;
			end
			if (top2_c) begin
				a2_c = a2_c ^ poly_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod <= acc2_c;
	end

endmodule

[rtl/erasure_parity_encoder.sv]
// ----------------------------------------------------------------------------
// erasure_parity_encoder: Reed-Solomon style parity encoder over GF(2^8/16)
// Coefficient loads fill a table memory; data symbols update parity rows.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: load items (cmd 0) write one coefficient to the table;
//         data items (cmd 1) arrive column by column, shard 0 first.
//   out_* channel: after the last data shard of a column, one parity item
//         per parity shard leaves in row order; column_last marks the final
//         one and block_last marks every item of the last column of a shard.
//   cfg_* channel: register writes; the user must issue them only while the
//         block is idle, which the block itself does not enforce.
// Datapath: a data item walks every parity row through a read of the
//   coefficient memory, a two-stage multiplier and a read-modify-write of
//   the accumulator memory; rows issue one per cycle, and the block takes
//   no new input item until it is idle again. Each parity item is read
//   from the accumulator memory before it leaves.
// Reset: registers return to their defaults, the accumulators and column
//   counter clear. The coefficient table is undefined until loaded.
// Stall: a stalled output item holds; the block waits without losing data.
// ----------------------------------------------------------------------------
module erasure_parity_encoder #(
	parameter int MAX_DATA_SHARDS   = 32,
	parameter int MAX_PARITY_SHARDS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  epe_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output epe_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_value
);
	import epe_pkg::*;

	localparam int DW    = (MAX_DATA_SHARDS > 1) ? $clog2(MAX_DATA_SHARDS) : 1;
	localparam int PLIM  = (MAX_PARITY_SHARDS < RESULT_LIMIT) ? MAX_PARITY_SHARDS
		: RESULT_LIMIT;
	localparam int PW    = (PLIM > 1) ? $clog2(PLIM) : 1;
	localparam int DEPTH = PLIM * MAX_DATA_SHARDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT_RD, ST_EMIT
	} state_t;

	// Configuration registers.
	logic        mode_q;
	logic [5:0]  dcount_q;
	logic [4:0]  pcount_q;
	logic [15:0] slen_q;
	logic [8:0]  pbyte_q;
	logic [16:0] pword_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			dcount_q <= 6'd10;
			pcount_q <= 5'd4;
			slen_q   <= 16'd1024;
			pbyte_q  <= 9'h11D;
			pword_q  <= 17'h1100B;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FIELD_MODE:   mode_q   <= cfg_value[0];
				REG_DATA_COUNT:   dcount_q <= cfg_value[5:0];
				REG_PARITY_COUNT: pcount_q <= cfg_value[4:0];
				REG_SHARD_LEN:    slen_q   <= cfg_value[15:0];
				REG_POLY_BYTE:    pbyte_q  <= cfg_value[8:0];
				REG_POLY_WORD:    pword_q  <= cfg_value;
				default: ;
			endcase
		end
	end

	// Effective counts after clamping.
	logic [8:0] dn;
	logic [6:0] pn;
	always_comb begin
		if (dcount_q == '0) begin
			dn = 9'd1;
		end else if (9'(dcount_q) > 9'(MAX_DATA_SHARDS)) begin
			dn = 9'(MAX_DATA_SHARDS);
		end else begin
			dn = 9'(dcount_q);
		end
		if (pcount_q == '0) begin
			pn = 7'd1;
		end else if (7'(pcount_q) > 7'(PLIM)) begin
			pn = 7'(PLIM);
		end else begin
			pn = 7'(pcount_q);
		end
	end

	logic [15:0] vmask;
	logic [15:0] poly_low;
	assign vmask    = mode_q ? 16'hFFFF : 16'h00FF;
	assign poly_low = mode_q ? pword_q[15:0] : {8'h00, pbyte_q[7:0]};

	// Memories.
	logic [15:0] coef_mem [DEPTH];
	logic [15:0] acc_mem  [PLIM];
	logic [15:0] coef_rd_q;
	logic [15:0] acc_rd_q;

	logic          coef_we;
	logic [AW-1:0] coef_wa;
	logic [AW-1:0] coef_ra;
	logic          acc_we;
	logic [PW-1:0] acc_wa;
	logic [15:0]   acc_wd;
	logic [PW-1:0] acc_ra;

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= in_data.symbol_value;
		end
		coef_rd_q <= coef_mem[coef_ra];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		acc_rd_q <= acc_mem[acc_ra];
	end

	// Control state.
	state_t      state_q;
	logic [6:0]  row_q;
	logic [DW-1:0] shard_q;
	logic [15:0] sym_q;
	logic        last_q;
	logic        blast_q;
	logic [15:0] col_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic [6:0]  emit_q;
	// Pipeline: coef read issued in ST_RUN, s1/s2 multiplier, s3 write.
	logic          v_s1, v_s2, v_s3;
	logic [PW-1:0] r_s1, r_s2, r_s3;
	logic [15:0]   prod;
	logic          rst_done_q;
	logic [PW-1:0] clr_q;
	// A row whose flag is low reads as zero; shard 0 drops every flag.
	logic [PLIM-1:0] acc_valid_q;

	epe_gf_mul u_mul (
		.clk       (clk),
		.a         (coef_rd_q & vmask),
		.b         (sym_q & vmask),
		.word_mode (mode_q),
		.poly_low  (poly_low),
		.prod      (prod)
	);

	// The accumulator of row r_s3 is read at s2 to be ready at s3.
	logic in_take;
	logic in_ok_shard;
	logic data_start;
	logic [15:0] len_m1;
	assign in_take     = in_valid && !in_stall;
	assign in_ok_shard = 9'(in_data.shard_index) < dn;
	assign data_start  = in_take && (in_data.cmd == CMD_DATA) && in_ok_shard;
	assign in_stall    = (state_q != ST_IDLE) || !rst_done_q;
	assign len_m1      = (slen_q == '0) ? 16'd0 : slen_q - 16'd1;

	always_comb begin
		coef_we = in_take && (in_data.cmd == CMD_LOAD)
			&& (32'(in_data.parity_row) < PLIM)
			&& (32'(in_data.shard_index) < MAX_DATA_SHARDS);
		coef_wa = AW'(32'(in_data.parity_row) * MAX_DATA_SHARDS
			+ 32'(in_data.shard_index));
		coef_ra = AW'(32'(row_q) * MAX_DATA_SHARDS + 32'(shard_q));
		acc_ra  = (state_q == ST_EMIT_RD || state_q == ST_EMIT) ? PW'(emit_q) : r_s2;
		acc_we  = !rst_done_q || v_s3;
		acc_wa  = !rst_done_q ? clr_q : r_s3;
		acc_wd  = !rst_done_q ? 16'h0000
			: ((acc_valid_q[r_s3] ? acc_rd_q : 16'h0000) ^ prod);
	end

	// Row flags: set on each write, all cleared when a column starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q <= '0;
		end else if (v_s3) begin
			acc_valid_q[r_s3] <= 1'b1;
		end else if (state_q == ST_IDLE && data_start && in_data.shard_index == '0) begin
			acc_valid_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			shard_q     <= '0;
			sym_q       <= '0;
			last_q      <= 1'b0;
			blast_q     <= 1'b0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			emit_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			r_s1        <= '0;
			r_s2        <= '0;
			r_s3        <= '0;
			rst_done_q  <= 1'b0;
			clr_q       <= '0;
		end else begin
			// Clearing pass over the accumulators after reset.
			if (!rst_done_q) begin
				clr_q <= clr_q + PW'(1);
				if (32'(clr_q) == PLIM - 1) begin
					rst_done_q <= 1'b1;
				end
			end
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			r_s2 <= r_s1;
			v_s3 <= v_s2;
			r_s3 <= r_s2;
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (data_start) begin
						shard_q <= DW'(in_data.shard_index);
						sym_q   <= in_data.symbol_value;
						last_q  <= (9'(in_data.shard_index) == dn - 9'd1);
						row_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					r_s1  <= PW'(row_q);
					row_q <= row_q + 7'd1;
					if (row_q == pn - 7'd1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						if (last_q) begin
							blast_q <= (col_q >= len_m1);
							col_q   <= (col_q >= len_m1) ? 16'd0 : col_q + 16'd1;
							emit_q  <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q        <= 1'b1;
						out_q.parity_value <= acc_rd_q & vmask;
						out_q.parity_index <= 4'(emit_q);
						out_q.column_last  <= (emit_q == pn - 7'd1);
						out_q.block_last   <= blast_q;
						emit_q             <= emit_q + 7'd1;
						state_q <= (emit_q == pn - 7'd1) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/epe_checker.sv]
// ----------------------------------------------------------------------------
// epe_checker: port-level checks of the erasure parity encoder
// Watches the handshakes and result ordering seen at the top level.
// ----------------------------------------------------------------------------
module epe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input epe_pkg::out_item_t out_data
);
	import epe_pkg::*;

	// A stalled result item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Results after a column-final item start again at row zero.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.column_last |=>
		!out_valid || out_data.parity_index == 4'd0 || $stable(out_data))
		else $error("new column did not start at row zero");

	// Handshake outputs are always known once out of reset.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown");

	// Row indexes of one column rise by one.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.column_last ##1 out_valid |->
		out_data.parity_index == $past(out_data.parity_index) + 4'd1)
		else $error("parity rows out of order");

endmodule

bind erasure_parity_encoder epe_checker u_epe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for erasure_parity_encoder
// Loads parity coefficients, streams data columns in both field modes and
// several shard configurations, and compares every parity item against a
// local GF(2^8)/GF(2^16) parity predictor, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import epe_pkg::*;

	localparam int NROWS = 16;
	localparam int NSHARDS = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [16:0] cfg_value = '0;

	erasure_parity_encoder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_value(cfg_value)
	);

	always #2 clk = ~clk;

	// Register copies as the block holds them.
	logic        word_mode = 1'b0;
	logic [5:0]  data_count = 6'd10;
	logic [4:0]  parity_count = 5'd4;
	logic [15:0] shard_len = 16'd1024;
	logic [8:0]  poly_byte = 9'h11D;
	logic [16:0] poly_word = 17'h1100B;

	// Encoder state mirrored by the predictor.
	logic [15:0] coef_mem [NROWS][NSHARDS];
	logic [15:0] parity_acc [NROWS];
	logic [15:0] column_cnt = '0;
	bit          coef_loaded [NROWS][NSHARDS];

	in_item_t  pending_items [$];
	out_item_t parity_expected [$];
	bit        failed = 1'b0;
	bit        calm = 1'b0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        cycles = 0;
	int        items_queued = 0;

	function automatic int eff_data();
		return (data_count < 1) ? 1 : (data_count > NSHARDS) ? NSHARDS : int'(data_count);
	endfunction

	function automatic int eff_parity();
		return (parity_count < 1) ? 1 : (parity_count > NROWS) ? NROWS : int'(parity_count);
	endfunction

	// Carry-less multiply with reduction; the polynomial's top bit is implied.
	function automatic logic [15:0] field_mul(logic [15:0] a, logic [15:0] b, bit wide,
			logic [15:0] red);
		int nb;
		logic [15:0] msk;
		logic [15:0] prod;
		nb = wide ? 16 : 8;
		msk = wide ? 16'hFFFF : 16'h00FF;
		prod = '0;
		a = a & msk;
		b = b & msk;
		for (int i = 0; i < nb; i++) begin
			if (b[i]) begin
				prod = prod ^ a;
			end
			if (a[nb-1]) begin
				a = ((a << 1) & msk) ^ (red & msk);
			end else begin
				a = (a << 1) & msk;
			end
		end
		return prod;
	endfunction

	// Update the mirrored state with one accepted item and queue its parity.
	task automatic encode_item(in_item_t it);
		int dn;
		int pn;
		bit blast;
		logic [15:0] vmask;
		logic [15:0] red;
		out_item_t res;
		dn = eff_data();
		pn = eff_parity();
		vmask = word_mode ? 16'hFFFF : 16'h00FF;
		red = word_mode ? poly_word[15:0] : {8'h00, poly_byte[7:0]};
		if (it.cmd == CMD_LOAD) begin
			coef_mem[it.parity_row][it.shard_index] = it.symbol_value;
			return;
		end
		if (it.shard_index >= dn) begin
			return;
		end
		if (it.shard_index == 0) begin
			for (int p = 0; p < NROWS; p++) parity_acc[p] = '0;
		end
		for (int p = 0; p < pn; p++) begin
			parity_acc[p] = parity_acc[p] ^ field_mul(coef_mem[p][it.shard_index],
				it.symbol_value, word_mode, red);
		end
		if (it.shard_index != dn - 1) begin
			return;
		end
		blast = (32'(column_cnt) + 1) >= ((shard_len == 0) ? 32'd1 : 32'(shard_len));
		for (int p = 0; p < pn; p++) begin
			res.parity_value = parity_acc[p] & vmask;
			res.parity_index = 4'(p);
			res.column_last = (p == pn - 1);
			res.block_last = blast;
			parity_expected.push_back(res);
		end
		column_cnt = blast ? 16'd0 : column_cnt + 16'd1;
	endtask

	// Input driver: one item per handshake, with a random gap after each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				encode_item(in_data);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
					gap_left <= calm ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each parity item and draws the next stall.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			if (parity_expected.size() == 0) begin
				$error("unexpected parity item %h", out_data);
				failed = 1'b1;
			end else begin
				want = parity_expected.pop_front();
				if (out_data.parity_value !== want.parity_value) begin
					$error("parity_value expected %h got %h", want.parity_value,
						out_data.parity_value);
					failed = 1'b1;
				end
				if (out_data.parity_index !== want.parity_index) begin
					$error("parity_index expected %0d got %0d", want.parity_index,
						out_data.parity_index);
					failed = 1'b1;
				end
				if (out_data.column_last !== want.column_last) begin
					$error("column_last expected %b got %b", want.column_last,
						out_data.column_last);
					failed = 1'b1;
				end
				if (out_data.block_last !== want.block_last) begin
					$error("block_last expected %b got %b", want.block_last,
						out_data.block_last);
					failed = 1'b1;
				end
			end
			n = calm ? 0 : $urandom_range(0, 3);
			stall_left <= n;
			out_stall <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** erasure_parity_encoder: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_value <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FIELD_MODE:   word_mode = val[0];
			REG_DATA_COUNT:   data_count = val[5:0];
			REG_PARITY_COUNT: parity_count = val[4:0];
			REG_SHARD_LEN:    shard_len = val[15:0];
			REG_POLY_BYTE:    poly_byte = val[8:0];
			REG_POLY_WORD:    poly_word = val[16:0];
			default: ;
		endcase
	endtask

	task automatic configure(bit fm, int dc, int pc, int len, int pb, int pw);
		write_reg(REG_FIELD_MODE, 17'(fm));
		write_reg(REG_DATA_COUNT, 17'(dc));
		write_reg(REG_PARITY_COUNT, 17'(pc));
		write_reg(REG_SHARD_LEN, 17'(len));
		write_reg(REG_POLY_BYTE, 17'(pb));
		write_reg(REG_POLY_WORD, 17'(pw));
	endtask

	// Wait until every item is in and every parity item is out, then settle.
	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || parity_expected.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_sym();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h00FF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void push_load(int r, int s, logic [15:0] v);
		in_item_t it;
		it.cmd = CMD_LOAD;
		it.parity_row = 4'(r);
		it.shard_index = 5'(s);
		it.symbol_value = v;
		coef_loaded[r][s] = 1'b1;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// A data item, preceded by loads for any coefficient it would read unset.
	function automatic void push_data(int s, logic [15:0] v);
		in_item_t it;
		if (s < eff_data()) begin
			for (int p = 0; p < eff_parity(); p++) begin
				if (!coef_loaded[p][s]) push_load(p, s, pick_sym());
			end
		end
		it.cmd = CMD_DATA;
		it.parity_row = 4'($urandom);
		it.shard_index = 5'(s);
		it.symbol_value = v;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_column(int first);
		for (int s = first; s < eff_data(); s++) push_data(s, 16'($urandom));
	endfunction

	// Mostly whole columns; now and then an ignored shard, a stray load or a
	// column that starts part way through.
	task automatic random_phase(int columns);
		for (int c = 0; c < columns; c++) begin
			case ($urandom_range(0, 9))
				0: if (eff_data() < NSHARDS) push_data($urandom_range(eff_data(), NSHARDS - 1),
					16'($urandom));
				1: push_load($urandom_range(0, NROWS - 1), $urandom_range(0, NSHARDS - 1),
					16'($urandom));
				2: push_column($urandom_range(0, eff_data() - 1));
				default: push_column(0);
			endcase
		end
		drain();
	endtask

	initial begin
		int len;
		for (int r = 0; r < NROWS; r++) begin
			parity_acc[r] = '0;
			for (int s = 0; s < NSHARDS; s++) begin
				coef_mem[r][s] = '0;
				coef_loaded[r][s] = 1'b0;
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: extreme coefficients and symbols, an ignored shard.
		for (int s = 0; s < 10; s++) push_data(s, 16'hFFFF);
		for (int s = 0; s < 10; s++) push_data(s, 16'h0000);
		for (int s = 0; s < 10; s++) push_data(s, (s % 2) ? 16'h0080 : 16'h8001);
		push_data(31, 16'hFFFF);
		push_load(15, 31, 16'hFFFF);
		drain();

		// Word mode with every shard, one row and a zero shard length.
		configure(1'b1, 32, 1, 0, 9'h11D, 17'h1100B);
		push_column(0);
		drain();

		// Clamped counts.
		configure(1'b0, 0, 31, 3, 9'h1FF, 17'h1FFFF);
		calm = 1'b1;
		random_phase(5);
		calm = 1'b0;
		configure(1'b1, 63, 0, 65535, 9'h100, 17'h10000);
		random_phase(1);
		configure(1'b0, 5, 3, 2, 9'h100, 17'h10000);
		random_phase(6);

		// Random settings until enough items have gone through.
		while (items_queued < 250) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
			configure($urandom_range(0, 1),
				($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8),
				$urandom_range(0, 5), len,
				$urandom_range(256, 511), $urandom_range(65536, 131071));
			calm = ($urandom_range(0, 3) == 0);
			random_phase($urandom_range(2, 5));
		end

		if (!failed) begin
			$display("** erasure_parity_encoder: PASSED **");
		end else begin
			$display("** erasure_parity_encoder: FAILED **");
		end
		$finish;
	end

endmodule

[erasure_parity_encoder.f]
rtl/epe_pkg.sv
rtl/epe_gf_mul.sv
rtl/erasure_parity_encoder.sv
rtl/epe_checker.sv
tb/testbench.sv
